// File: design/dms_pkg.sv
// shared types, constants and factor tables of the degraded mode supervisor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_DEGRADED = 2'd1,
        MODE_LIMP     = 2'd2,
        MODE_CRITICAL = 2'd3
    } mode_t;

    // register index as seen on paddr[4:2]
    typedef enum logic [2:0] {
        REG_FORCE_ENABLE  = 3'd0,
        REG_FORCED_MODE   = 3'd1,
        REG_HYSTERESIS    = 3'd2,
        REG_BATT_CRITICAL = 3'd3,
        REG_BATT_LOW      = 3'd4,
        REG_TEMP_WARNING  = 3'd5,
        REG_TEMP_CRITICAL = 3'd6,
        REG_UNUSED        = 3'd7
    } reg_idx_t;

    localparam int NUM_MOTORS  = 4;
    localparam int NUM_MODES   = 4;
    localparam int TEMP_W      = 12;
    localparam int FACTOR_W    = 11;
    localparam int POWER_W     = 10;
    localparam int ASSIST_W    = 11;
    localparam int SPEED_W     = 15;

    localparam logic [15:0] HYSTERESIS_RST    = 16'd500;
    localparam logic [15:0] BATT_CRITICAL_RST = 16'd18000;
    localparam logic [15:0] BATT_LOW_RST      = 16'd20000;
    localparam logic signed [TEMP_W-1:0] TEMP_WARNING_RST  = 12'sd800;
    localparam logic signed [TEMP_W-1:0] TEMP_CRITICAL_RST = 12'sd900;

    localparam logic [7:0] ERR_CRITICAL = 8'd5;
    localparam logic [7:0] ERR_LIMP     = 8'd3;
    localparam logic [7:0] ERR_DEGRADED = 8'd1;

    localparam logic [POWER_W-1:0]  PEDAL_MAX  = 10'd1000;
    localparam logic [ASSIST_W-1:0] ASSIST_MAX = 11'd1024;
    localparam logic [9:0]          Q10_HALF   = 10'd512;

    typedef struct packed {
        logic [FACTOR_W-1:0] power;
        logic [FACTOR_W-1:0] steer;
        logic [FACTOR_W-1:0] speed;
    } factors_t;

    typedef struct packed {
        logic warn;
        logic crit;
    } temp_flags_t;

    typedef struct packed {
        logic                   force_enable;
        mode_t                  forced_mode;
        logic [15:0]            hysteresis_ms;
        logic [15:0]            battery_critical_mv;
        logic [15:0]            battery_low_mv;
    } mode_cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic [2:0]  health_flags;
        logic [7:0]  error_count;
        logic [15:0] battery_mv;
        logic        temp_warn;
        logic        temp_crit;
    } eval_in_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] time_in_mode_ms;
        logic        battery_low;
        logic        clear_force;
    } eval_out_t;

    typedef struct packed {
        logic [POWER_W-1:0]  power;
        logic [ASSIST_W-1:0] assist;
        logic [SPEED_W-1:0]  speed;
    } scaled_t;

    // Q1.10 factors per mode, rounded to nearest
    function automatic factors_t mode_factors(input mode_t m);
        factors_t f;
        unique case (m)
            MODE_NORMAL:   f = '{power: 11'd1024, steer: 11'd1024, speed: 11'd1024};
            MODE_DEGRADED: f = '{power: 11'd717,  steer: 11'd819,  speed: 11'd819};
            MODE_LIMP:     f = '{power: 11'd410,  steer: 11'd512,  speed: 11'd512};
            MODE_CRITICAL: f = '{power: 11'd154,  steer: 11'd307,  speed: 11'd256};
            default:       f = '{power: 11'd1024, steer: 11'd1024, speed: 11'd1024};
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: design/degraded_mode_supervisor.sv
// Degraded mode supervisor: one beat in, one beat out, every cycle unless a full output
// register is held by m_tready low. Each input beat carries a tick's health snapshot;
// four temperature lanes compare the motor readings side by side, a merge stage ORs
// their flags, the mode evaluation picks the required mode by priority (critical, limp,
// degraded, normal), and four scaling lanes, one per mode, scale the clamped pedal,
// assist and speed requests so that the result of the chosen mode is simply selected. A
// mode change is taken only once hysteresis_ms has passed since the last change (wrapping
// 32-bit difference); a forced mode bypasses evaluation and hysteresis, and a beat with
// s_tuser high returns to normal and clears force_enable. Throughput is one beat per
// cycle, and s_tready stays high, while m_tready is high or the output register is empty:
// the output register doubles as the stage between the two sides, and the mode state
// loop closes through its own register. Configuration goes through the APB port;
// registers sit at byte addresses 4*i and should be written while no beat is in flight.
// depends on dms_pkg, dms_temp_lane, dms_scale_lane, dms_mode_eval
`timescale 1ns / 1ps
`default_nettype none

module degraded_mode_supervisor
    import dms_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    // input beat
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind (1 = return to normal)
    input  wire logic         s_tuser,
    // now_ms[31:0], health_flags[34:32], error_count[42:35], battery_mv[58:43],
    // motor_temp_a[70:59], motor_temp_b[82:71], motor_temp_c[94:83],
    // motor_temp_d[106:95], pedal_request[117:107], assist_request[129:118],
    // speed_request[145:130], zero[151:146]
    input  wire logic [151:0] s_tdata,

    // result beat
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // mode[1:0], power_out[11:2], assist_out[22:12], speed_out[37:23],
    // safe_to_operate[38], full_power_allowed[39], battery_low[40],
    // over_temp[41], time_in_mode_ms[73:42], zero[79:74]
    output logic [79:0]       m_tdata,

    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration registers
    logic                     force_enable_reg, force_enable_next;
    mode_t                    forced_mode_reg, forced_mode_next;
    logic [15:0]              hysteresis_reg, hysteresis_next;
    logic [15:0]              batt_crit_reg, batt_crit_next;
    logic [15:0]              batt_low_reg, batt_low_next;
    logic signed [TEMP_W-1:0] temp_warn_reg, temp_warn_next;
    logic signed [TEMP_W-1:0] temp_crit_reg, temp_crit_next;

    // output stage
    logic        m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg, m_tdata_next;

    logic        accept;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    // input fields
    logic [31:0]              in_now;
    logic [2:0]               in_flags;
    logic [7:0]               in_errs;
    logic [15:0]              in_batt;
    logic signed [TEMP_W-1:0] in_temp [NUM_MOTORS];
    logic signed [10:0]       in_pedal;
    logic signed [11:0]       in_assist;
    logic signed [15:0]       in_speed;

    // clamped requests
    logic [POWER_W-1:0]  pedal_c;
    logic [ASSIST_W-1:0] assist_c;
    logic [SPEED_W-1:0]  speed_c;

    temp_flags_t lane_flags [NUM_MOTORS];
    scaled_t     lane_scaled [NUM_MODES];
    scaled_t     sel_scaled;
    logic        any_warn, any_crit;

    mode_cfg_t   mode_cfg;
    eval_in_t    ev_in;
    eval_out_t   ev_out;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);

    // unpack the input beat
    always_comb begin
        in_now     = s_tdata[31:0];
        in_flags   = s_tdata[34:32];
        in_errs    = s_tdata[42:35];
        in_batt    = s_tdata[58:43];
        in_temp[0] = s_tdata[70:59];
        in_temp[1] = s_tdata[82:71];
        in_temp[2] = s_tdata[94:83];
        in_temp[3] = s_tdata[106:95];
        in_pedal   = s_tdata[117:107];
        in_assist  = s_tdata[129:118];
        in_speed   = s_tdata[145:130];
    end

    // request clamps: pedal to 0..1000, assist to 0..1024, speed to 0 and up
    always_comb begin
        if (in_pedal < 0) begin
            pedal_c = '0;
        end else if (in_pedal > $signed({1'b0, PEDAL_MAX})) begin
            pedal_c = PEDAL_MAX;
        end else begin
            pedal_c = in_pedal[POWER_W-1:0];
        end

        if (in_assist < 0) begin
            assist_c = '0;
        end else if (in_assist > $signed({1'b0, ASSIST_MAX})) begin
            assist_c = ASSIST_MAX;
        end else begin
            assist_c = in_assist[ASSIST_W-1:0];
        end

        speed_c = in_speed[15] ? '0 : in_speed[SPEED_W-1:0];
    end

    // temperature lanes, one per motor
    for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_temp
        dms_temp_lane u_temp (
            .temp     (in_temp[g]),
            .warn_thr (temp_warn_reg),
            .crit_thr (temp_crit_reg),
            .flags    (lane_flags[g])
        );
    end

    // merge the lane flags
    always_comb begin
        any_warn = 1'b0;
        any_crit = 1'b0;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            any_warn = any_warn | lane_flags[i].warn;
            any_crit = any_crit | lane_flags[i].crit;
        end
    end

    always_comb begin
        mode_cfg.force_enable        = force_enable_reg;
        mode_cfg.forced_mode         = forced_mode_reg;
        mode_cfg.hysteresis_ms       = hysteresis_reg;
        mode_cfg.battery_critical_mv = batt_crit_reg;
        mode_cfg.battery_low_mv      = batt_low_reg;

        ev_in.kind         = s_tuser;
        ev_in.now_ms       = in_now;
        ev_in.health_flags = in_flags;
        ev_in.error_count  = in_errs;
        ev_in.battery_mv   = in_batt;
        ev_in.temp_warn    = any_warn;
        ev_in.temp_crit    = any_crit;
    end

    dms_mode_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cfg     (mode_cfg),
        .ev_in   (ev_in),
        .ev_out  (ev_out)
    );

    // scaling lanes, one per mode; the new mode selects the lane
    for (genvar g = 0; g < NUM_MODES; g++) begin : g_scale
        dms_scale_lane u_scale (
            .pedal   (pedal_c),
            .assist  (assist_c),
            .speed   (speed_c),
            .factors (mode_factors(mode_t'(g))),
            .scaled  (lane_scaled[g])
        );
    end

    assign sel_scaled = lane_scaled[ev_out.mode];

    // output stage: loads on every accepted beat, drains on m_tready
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0,
                             ev_out.time_in_mode_ms,
                             any_warn,
                             ev_out.battery_low,
                             ev_out.mode == MODE_NORMAL,
                             ev_out.mode == MODE_NORMAL || ev_out.mode == MODE_DEGRADED,
                             sel_scaled.speed,
                             sel_scaled.assist,
                             sel_scaled.power,
                             ev_out.mode};
        end
    end

    // register writes; a return-to-normal beat also drops force_enable
    always_comb begin
        force_enable_next = force_enable_reg;
        forced_mode_next  = forced_mode_reg;
        hysteresis_next   = hysteresis_reg;
        batt_crit_next    = batt_crit_reg;
        batt_low_next     = batt_low_reg;
        temp_warn_next    = temp_warn_reg;
        temp_crit_next    = temp_crit_reg;
        if (ev_out.clear_force) begin
            force_enable_next = 1'b0;
        end
        if (cfg_write) begin
            unique case (cfg_idx)
                REG_FORCE_ENABLE:  force_enable_next = pwdata[0];
                REG_FORCED_MODE:   forced_mode_next  = mode_t'(pwdata[1:0]);
                REG_HYSTERESIS:    hysteresis_next   = pwdata[15:0];
                REG_BATT_CRITICAL: batt_crit_next    = pwdata[15:0];
                REG_BATT_LOW:      batt_low_next     = pwdata[15:0];
                REG_TEMP_WARNING:  temp_warn_next    = pwdata[TEMP_W-1:0];
                REG_TEMP_CRITICAL: temp_crit_next    = pwdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_FORCE_ENABLE:  prdata = {31'd0, force_enable_reg};
            REG_FORCED_MODE:   prdata = {30'd0, forced_mode_reg};
            REG_HYSTERESIS:    prdata = {16'd0, hysteresis_reg};
            REG_BATT_CRITICAL: prdata = {16'd0, batt_crit_reg};
            REG_BATT_LOW:      prdata = {16'd0, batt_low_reg};
            REG_TEMP_WARNING:  prdata = {20'd0, temp_warn_reg};
            REG_TEMP_CRITICAL: prdata = {20'd0, temp_crit_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_enable_reg <= 1'b0;
            forced_mode_reg  <= MODE_NORMAL;
            hysteresis_reg   <= HYSTERESIS_RST;
            batt_crit_reg    <= BATT_CRITICAL_RST;
            batt_low_reg     <= BATT_LOW_RST;
            temp_warn_reg    <= TEMP_WARNING_RST;
            temp_crit_reg    <= TEMP_CRITICAL_RST;
            m_tvalid_reg     <= 1'b0;
        end else begin
            force_enable_reg <= force_enable_next;
            forced_mode_reg  <= forced_mode_next;
            hysteresis_reg   <= hysteresis_next;
            batt_crit_reg    <= batt_crit_next;
            batt_low_reg     <= batt_low_next;
            temp_warn_reg    <= temp_warn_next;
            temp_crit_reg    <= temp_crit_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// File: design/dms_temp_lane.sv
// one motor temperature lane: compares a reading with both thresholds
// depends on dms_pkg
`timescale 1ns / 1ps
`default_nettype none

module dms_temp_lane
    import dms_pkg::*;
(
    input  wire logic signed [TEMP_W-1:0] temp,
    input  wire logic signed [TEMP_W-1:0] warn_thr,
    input  wire logic signed [TEMP_W-1:0] crit_thr,
    output temp_flags_t                   flags
);

    always_comb begin
        flags.warn = temp > warn_thr;
        flags.crit = temp > crit_thr;
    end

endmodule

`default_nettype wire

// File: design/dms_scale_lane.sv
// one scaling lane: clamped requests times one mode's Q1.10 factors, rounded
// depends on dms_pkg
`timescale 1ns / 1ps
`default_nettype none

module dms_scale_lane
    import dms_pkg::*;
(
    input  wire logic [POWER_W-1:0]  pedal,
    input  wire logic [ASSIST_W-1:0] assist,
    input  wire logic [SPEED_W-1:0]  speed,
    input  wire factors_t            factors,
    output scaled_t                  scaled
);

    logic [POWER_W+FACTOR_W-1:0]  p_prod;
    logic [ASSIST_W+FACTOR_W-1:0] a_prod;
    logic [SPEED_W+FACTOR_W-1:0]  s_prod;

    // sums stay below 2^20, 2^21 and 2^25, so the slices lose nothing
    always_comb begin
        p_prod = POWER_W'(pedal) * factors.power + (POWER_W + FACTOR_W)'(Q10_HALF);
        a_prod = ASSIST_W'(assist) * factors.steer + (ASSIST_W + FACTOR_W)'(Q10_HALF);
        s_prod = SPEED_W'(speed) * factors.speed + (SPEED_W + FACTOR_W)'(Q10_HALF);
        scaled.power  = p_prod[POWER_W+9:10];
        scaled.assist = a_prod[ASSIST_W+9:10];
        scaled.speed  = s_prod[SPEED_W+9:10];
    end

endmodule

`default_nettype wire

// File: design/dms_mode_eval.sv
// prioritized mode evaluation, hysteresis and mode state
// depends on dms_pkg
`timescale 1ns / 1ps
`default_nettype none

module dms_mode_eval
    import dms_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      accept,
    input  wire mode_cfg_t cfg,
    input  wire eval_in_t  ev_in,
    output eval_out_t      ev_out
);

    mode_t       mode_reg, mode_next;
    logic [31:0] last_change_reg, last_change_next;

    logic        pedal_ok, steer_ok, centered;
    logic        b_crit, b_low;
    logic [31:0] elapsed;
    mode_t       req;
    mode_t       target;
    logic        changed;

    always_comb begin
        pedal_ok = ev_in.health_flags[0];
        steer_ok = ev_in.health_flags[1];
        centered = ev_in.health_flags[2];
        b_crit   = (ev_in.battery_mv != '0) && (ev_in.battery_mv < cfg.battery_critical_mv);
        b_low    = (ev_in.battery_mv != '0) && (ev_in.battery_mv < cfg.battery_low_mv);
        elapsed  = ev_in.now_ms - last_change_reg;

        if ((!pedal_ok && !steer_ok) || b_crit || ev_in.temp_crit
                || ev_in.error_count >= ERR_CRITICAL) begin
            req = MODE_CRITICAL;
        end else if (ev_in.error_count >= ERR_LIMP || b_low || !centered
                || !pedal_ok || !steer_ok) begin
            req = MODE_LIMP;
        end else if (ev_in.error_count >= ERR_DEGRADED || ev_in.temp_warn) begin
            req = MODE_DEGRADED;
        end else begin
            req = MODE_NORMAL;
        end

        if (ev_in.kind) begin
            target  = MODE_NORMAL;
            changed = 1'b1;
        end else if (cfg.force_enable) begin
            target  = cfg.forced_mode;
            changed = cfg.forced_mode != mode_reg;
        end else begin
            target  = req;
            changed = (req != mode_reg) && (elapsed >= 32'(cfg.hysteresis_ms));
        end

        ev_out.mode            = changed ? target : mode_reg;
        ev_out.time_in_mode_ms = changed ? '0 : elapsed;
        ev_out.battery_low     = b_low;
        ev_out.clear_force     = accept && ev_in.kind;

        mode_next        = mode_reg;
        last_change_next = last_change_reg;
        if (accept && changed) begin
            mode_next        = target;
            last_change_next = ev_in.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_NORMAL;
            last_change_reg <= '0;
        end else begin
            mode_reg        <= mode_next;
            last_change_reg <= last_change_next;
        end
    end

`ifndef SYNTHESIS
    a_reset_normal: assert property (@(posedge aclk)
        !aresetn |=> (mode_reg == MODE_NORMAL && last_change_reg == '0))
        else $error("mode state not cleared by reset");

    a_return_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ev_in.kind) |=>
            (mode_reg == MODE_NORMAL && last_change_reg == $past(ev_in.now_ms)))
        else $error("return to normal not taken");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(mode_reg) && $stable(last_change_reg)))
        else $error("mode state moved without a beat");

    a_change_stamps: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && mode_reg != $past(mode_reg)) |->
            ($past(accept) && last_change_reg == $past(ev_in.now_ms)))
        else $error("mode change without timestamp update");
`endif

endmodule

`default_nettype wire
